// ===== sv/jfps_pkg.sv =====
// ----------------------------------------------------------------------------
// jfps_pkg: shared definitions for the five-point Jacobi stencil
// Field widths, register indexes, reset values and pipeline stage types.
// ----------------------------------------------------------------------------
package jfps_pkg;

  localparam int DATA_W     = 32;
  localparam int COLS_W     = 11;
  localparam int ROWS_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MIN_DIM      = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_ENABLE = 2'd2;

  localparam logic [COLS_W-1:0] GRID_COLS_RST    = 11'd1024;
  localparam logic [ROWS_W-1:0] GRID_ROWS_RST    = 16'd1024;
  localparam logic              ERROR_ENABLE_RST = 1'b1;

  // token flags carried down the datapath
  typedef struct packed {
    logic prod;  // interior point, gives a result
    logic clr;   // frame end, clears the running error
    logic last;  // final interior point of the frame
  } tok_t;

  typedef struct packed {
    tok_t               tok;
    logic [DATA_W-1:0]  up;
    logic [DATA_W-1:0]  dn;
    logic [DATA_W-1:0]  lf;
    logic [DATA_W-1:0]  rt;
    logic [DATA_W-1:0]  ce;
  } opnd_t;

  typedef struct packed {
    tok_t               tok;
    logic [DATA_W-1:0]  val;
    logic [DATA_W-1:0]  ce;
  } avg_t;

  typedef struct packed {
    tok_t               tok;
    logic [DATA_W-1:0]  val;
    logic [DATA_W-1:0]  mag;
  } chg_t;

endpackage

// ===== sv/jacobi_five_point_stencil.sv =====
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil: streaming five-point Jacobi relaxation
// Raster-order Q16.16 samples in, averaged interior points out, with the
// running maximum absolute change of the frame.
// ----------------------------------------------------------------------------
//
//  channel | dir | ports                                         | beat taken when
//  --------+-----+-----------------------------------------------+-------------------
//  in      | in  | in_sample                                     | in_valid & in_ready
//  out     | out | out_new_value, out_max_error, out_last_point  | out_valid & out_ready
//  cfg     | in  | cfg_index, cfg_data                           | cfg_valid & cfg_ready
//
//  One input beat per clock unless out stalls; the line stores give both rows
//  above the current sample in the same cycle, one read and one write per store.
//  A result passes through stage 1, stage 2, stage 3 and the output register.
//  Reset (rst_n low, synchronous) clears counters, window, running error and
//  config; line store contents stay undefined until written.
//  Four register stages decouple in and out: in_ready drops only when all of
//  them hold a beat and out is stalled.
//
module jacobi_five_point_stencil
  import jfps_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_W-1:0]     in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_W-1:0]     out_new_value,
  output logic        [DATA_W-1:0]     out_max_error,
  output logic                         out_last_point,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [CFG_IDX_W-1:0]  cfg_index,
  input  logic        [CFG_DATA_W-1:0] cfg_data
);

  // address width of a line store, and a width that holds MAX_COLS and grid_cols
  localparam int AW  = $clog2(MAX_COLS);
  localparam int CLW = (AW + 1 > COLS_W) ? AW + 1 : COLS_W;

  // --------------------------------------------------------------------------
  // configuration registers; writes are always accepted, with cfg_ready high every cycle
  // --------------------------------------------------------------------------
  logic [COLS_W-1:0] grid_cols_r;
  logic [ROWS_W-1:0] grid_rows_r;
  logic              error_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r    <= GRID_COLS_RST;
      grid_rows_r    <= GRID_ROWS_RST;
      error_enable_r <= ERROR_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_COLS:    grid_cols_r    <= cfg_data[COLS_W-1:0];
        CFG_GRID_ROWS:    grid_rows_r    <= cfg_data[ROWS_W-1:0];
        CFG_ERROR_ENABLE: error_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp the grid size to the legal range
  logic [CLW-1:0]    gc_ext;
  logic [CLW-1:0]    cols;
  logic [ROWS_W-1:0] rows;

  always_comb begin
    gc_ext = CLW'(grid_cols_r);
    if (gc_ext < CLW'(MIN_DIM)) begin
      cols = CLW'(MIN_DIM);
    end else if (gc_ext > CLW'(MAX_COLS)) begin
      cols = CLW'(MAX_COLS);
    end else begin
      cols = gc_ext;
    end
    rows = (grid_rows_r < ROWS_W'(MIN_DIM)) ? ROWS_W'(MIN_DIM) : grid_rows_r;
  end

  // --------------------------------------------------------------------------
  // pipeline handshake: each stage takes a beat when it is empty or draining
  // --------------------------------------------------------------------------
  logic  s1_v_r, s2_v_r, s3_v_r;
  opnd_t s1_r;
  avg_t  s2_r;
  chg_t  s3_r;
  logic  out_valid_r;
  logic  out_free, s3_free, s2_free, s1_free;
  logic  s3_mv;
  logic  in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign s3_mv    = s3_v_r && out_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // raster position
  // --------------------------------------------------------------------------
  logic [AW-1:0]     col_cnt_r, col_nxt;
  logic [ROWS_W-1:0] row_cnt_r, row_nxt;
  logic [CLW-1:0]    c_p1, c_p2;
  logic [ROWS_W:0]   r_p1;
  logic              row_end, frame_end, interior, last_pt;

  always_comb begin
    c_p1      = CLW'(col_cnt_r) + CLW'(1);
    c_p2      = CLW'(col_cnt_r) + CLW'(2);
    r_p1      = {1'b0, row_cnt_r} + 1'b1;
    row_end   = (c_p1 >= cols);
    frame_end = row_end && (r_p1 >= {1'b0, rows});
    interior  = (row_cnt_r >= ROWS_W'(2)) && (row_cnt_r < rows) &&
                (col_cnt_r != '0) && (c_p1 < cols);
    last_pt   = (r_p1 == {1'b0, rows}) && (c_p2 == cols);
    col_nxt   = col_cnt_r;
    row_nxt   = row_cnt_r;
    if (in_fire) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : r_p1[ROWS_W-1:0];
      end else begin
        col_nxt = c_p1[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // line stores: upper holds row r-2, middle row r-1. Read every cycle, upper at
  // the next beat's column, middle one to its right, so both are ready when that
  // beat arrives. The write goes to the current column, never equal to either
  // read address (at least three columns), so no forwarding is needed.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] upper_line_r  [MAX_COLS];
  logic [DATA_W-1:0] middle_line_r [MAX_COLS];
  logic [DATA_W-1:0] up_rd_r, mid_rd_r;
  logic [AW-1:0]     rd_up_addr, rd_mid_addr, wr_idx;
  logic [AW:0]       col_nxt_p1;

  assign col_nxt_p1  = {1'b0, col_nxt} + 1'b1;
  assign rd_up_addr  = col_nxt;
  assign rd_mid_addr = col_nxt_p1[AW-1:0];
  assign wr_idx      = col_cnt_r;

  // middle window: left, centre, right of the row above
  logic [DATA_W-1:0] w0_r, w1_r, w2_r;
  logic [DATA_W-1:0] w0_nxt, w1_nxt, w2_nxt;
  logic [DATA_W-1:0] row0_r;  // column 0 of the row above (middle entry 0)

  always_comb begin
    if (col_cnt_r == '0) begin
      w0_nxt = '0;
      w1_nxt = row0_r;
      w2_nxt = mid_rd_r;
    end else begin
      w0_nxt = w1_r;
      w1_nxt = w2_r;
      w2_nxt = (c_p1 < cols) ? mid_rd_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      // move the old middle entry up a row, store the new sample
      upper_line_r[wr_idx]  <= w1_nxt;
      middle_line_r[wr_idx] <= in_sample;
    end
    up_rd_r  <= upper_line_r[rd_up_addr];
    mid_rd_r <= middle_line_r[rd_mid_addr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && (col_cnt_r == '0)) begin
      row0_r <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w0_r <= '0;
      w1_r <= '0;
      w2_r <= '0;
    end else if (in_fire) begin
      w0_r <= w0_nxt;
      w1_r <= w1_nxt;
      w2_r <= w2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: capture the five stencil operands. Beats that are neither an
  // interior point nor the frame end drop here.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_fire && (interior || frame_end);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_r.tok.prod <= interior;
      s1_r.tok.clr  <= frame_end;
      s1_r.tok.last <= last_pt;
      s1_r.up       <= up_rd_r;
      s1_r.dn       <= in_sample;
      s1_r.lf       <= w0_nxt;
      s1_r.rt       <= w2_nxt;
      s1_r.ce       <= w1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: exact sum, floor of a quarter
  // --------------------------------------------------------------------------
  logic signed [DATA_W+1:0] sum4;

  assign sum4 = (DATA_W+2)'($signed(s1_r.up)) + (DATA_W+2)'($signed(s1_r.dn)) +
                (DATA_W+2)'($signed(s1_r.lf)) + (DATA_W+2)'($signed(s1_r.rt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_r.tok <= s1_r.tok;
      s2_r.val <= sum4[DATA_W+1:2];
      s2_r.ce  <= s1_r.ce;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: absolute change against the old centre
  // --------------------------------------------------------------------------
  logic signed [DATA_W:0] diff;
  logic        [DATA_W:0] diff_abs;

  always_comb begin
    diff     = (DATA_W+1)'($signed(s2_r.val)) - (DATA_W+1)'($signed(s2_r.ce));
    diff_abs = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free) begin
      s3_r.tok <= s2_r.tok;
      s3_r.val <= s2_r.val;
      s3_r.mag <= diff_abs[DATA_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // output stage: update the running maximum in beat order, then hold the
  // result until taken. A frame-end token clears the maximum, shows nothing.
  // --------------------------------------------------------------------------
  logic [DATA_W-1:0] run_err_r, run_err_nxt;
  logic [DATA_W-1:0] err_max;

  always_comb begin
    err_max     = (s3_r.mag > run_err_r) ? s3_r.mag : run_err_r;
    run_err_nxt = run_err_r;
    if (s3_mv) begin
      if (s3_r.tok.clr) begin
        run_err_nxt = '0;
      end else if (s3_r.tok.prod && error_enable_r) begin
        run_err_nxt = err_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_err_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_err_r <= run_err_nxt;
      if (s3_mv) begin
        out_valid_r <= s3_r.tok.prod;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_mv && s3_r.tok.prod) begin
      out_new_value  <= s3_r.val;
      out_max_error  <= error_enable_r ? err_max : '0;
      out_last_point <= s3_r.tok.last;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (wr_idx != rd_up_addr) && (wr_idx != rd_mid_addr))
    else $error("line store write hits a pending read address");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (CLW'(col_cnt_r) < CLW'(MAX_COLS)))
    else $error("column counter beyond line store depth");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && frame_end |=> (col_cnt_r == '0) && (row_cnt_r == '0))
    else $error("raster position not cleared at frame end");

  a_err_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s3_mv && s3_r.tok.clr |=> (run_err_r == '0) && !out_valid_r)
    else $error("frame end did not clear the running error");

endmodule

// ===== tb/jfps_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// jfps_scoreboard_pkg: stencil predictor and result scoreboard
// Tracks the line stores, window, counters and registers of the five-point
// stencil to work out each averaged point, then checks the block's results
// against them in order.
// ----------------------------------------------------------------------------
package jfps_scoreboard_pkg;

  import jfps_pkg::*;

  localparam int LINE_DEPTH = MAX_COLS_DEF;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] change;
    logic              last;
  } stencil_point_t;

  class stencil_scoreboard;

    int unsigned       failures;
    stencil_point_t    pending_points[$];

    logic [COLS_W-1:0] grid_cols;
    logic [ROWS_W-1:0] grid_rows;
    logic              error_enable;

    logic [DATA_W-1:0] upper_row [LINE_DEPTH];
    logic [DATA_W-1:0] middle_row [LINE_DEPTH];
    logic [DATA_W-1:0] window [3];
    int unsigned       col_cnt;
    int unsigned       row_cnt;
    logic [DATA_W-1:0] peak_change;

    function new();
      failures     = 0;
      grid_cols    = GRID_COLS_RST;
      grid_rows    = GRID_ROWS_RST;
      error_enable = ERROR_ENABLE_RST;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_cnt     = 0;
      row_cnt     = 0;
      peak_change = '0;
    endfunction

    function int unsigned eff_cols();
      if (grid_cols < COLS_W'(MIN_DIM)) return MIN_DIM;
      if (grid_cols > COLS_W'(LINE_DEPTH)) return LINE_DEPTH;
      return 32'(grid_cols);
    endfunction

    function int unsigned eff_rows();
      if (grid_rows < ROWS_W'(MIN_DIM)) return MIN_DIM;
      return 32'(grid_rows);
    endfunction

    function bit at_frame_start();
      return col_cnt == 0 && row_cnt == 0;
    endfunction

    function int unsigned outstanding();
      return pending_points.size();
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_COLS:    grid_cols = data[COLS_W-1:0];
        CFG_GRID_ROWS:    grid_rows = data[ROWS_W-1:0];
        CFG_ERROR_ENABLE: error_enable = data[0];
        default: ;
      endcase
    endfunction

    // Advance the grid by one accepted sample; queue the point it completes.
    function void note_sample(input logic [DATA_W-1:0] s);
      int unsigned    cols;
      int unsigned    rows;
      int unsigned    c;
      int unsigned    r;
      longint         up;
      longint         dn;
      longint         lf;
      longint         rt;
      longint         ce;
      longint         total;
      longint         avg;
      longint         delta;
      logic [DATA_W-1:0] mag;
      stencil_point_t pt;
      cols = eff_cols();
      rows = eff_rows();
      c    = col_cnt;
      r    = row_cnt;

      if (c == 0) begin
        window[0] = '0;
        window[1] = middle_row[0];
        window[2] = middle_row[1];
      end else begin
        window[0] = window[1];
        window[1] = window[2];
        window[2] = (c + 1 < cols) ? middle_row[c + 1] : '0;
      end

      if (r >= 2 && r <= rows - 1 && c >= 1 && c <= cols - 2) begin
        up    = longint'($signed(upper_row[c]));
        dn    = longint'($signed(s));
        lf    = longint'($signed(window[0]));
        ce    = longint'($signed(window[1]));
        rt    = longint'($signed(window[2]));
        total = up + dn + lf + rt;
        avg   = total >>> 2;
        delta = avg - ce;
        if (delta < 0) delta = -delta;
        mag = delta[DATA_W-1:0];
        if (error_enable && mag > peak_change) peak_change = mag;
        pt.value  = avg[DATA_W-1:0];
        pt.change = error_enable ? peak_change : '0;
        pt.last   = (r == rows - 1 && c == cols - 2);
        pending_points.push_back(pt);
      end

      if (c < LINE_DEPTH) begin
        upper_row[c]  = middle_row[c];
        middle_row[c] = s;
      end

      if (c + 1 >= cols) begin
        col_cnt = 0;
        if (r + 1 >= rows) begin
          row_cnt     = 0;
          peak_change = '0;
        end else begin
          row_cnt = r + 1;
        end
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    task report(input string what, input logic [DATA_W-1:0] got,
                input logic [DATA_W-1:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      failures++;
    endtask

    task check_point(input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] change,
                     input logic last);
      stencil_point_t want;
      if (pending_points.size() == 0) begin
        report("result with nothing outstanding", value, '0);
        return;
      end
      want = pending_points.pop_front();
      if (value !== want.value) report("new_value", value, want.value);
      if (change !== want.change) report("max_error", change, want.change);
      if (last !== want.last) report("last_point", {31'b0, last}, {31'b0, want.last});
    endtask

  endclass

endpackage

// ===== tb/jacobi_five_point_stencil_tb.sv =====
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil_tb: self-checking bench for the stencil block
// Streams raster-order Q16.16 grids through the block under changing grid
// sizes and error modes, with random gaps and stalls on both channels, and
// checks every averaged point against an in-bench predictor.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import jfps_pkg::*;
  import jfps_scoreboard_pkg::*;

  // index 3 maps to no register; writes to it must leave the block alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [DATA_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAMPLE_MIN = 32'h8000_0000;

  localparam int RANDOM_ITEMS = 1360;    // beats the phase loop sends at least
  localparam int BIG_FRAME_AT = 150;
  localparam int WIDE_TAIL    = 4;       // columns of the short rows after the wide one
  localparam int SETTLE       = 8;       // covers the pipeline registers
  localparam int RUN_LIMIT_NS = 2_000_000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [DATA_W-1:0]      in_sample = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [DATA_W-1:0]      out_new_value;
  logic        [DATA_W-1:0]      out_max_error;
  logic                          out_last_point;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic        [CFG_IDX_W-1:0]   cfg_index = '0;
  logic        [CFG_DATA_W-1:0]  cfg_data = '0;

  // idle-free stretches per side, drawn at random for each phase
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  stencil_scoreboard sb;

  // Three 3x3 frames, one interior point each (centre at index 4; up 1,
  // left 3, right 5, down 7):
  //  - all neighbours at the negative extreme, centre at the positive one:
  //    average hits the minimum, change is the widest possible
  //  - everything at the positive extreme: change 0, shows the frame-end clear
  //  - mixed signs summing to -3: floor gives -1 (run with error tracking off)
  logic [DATA_W-1:0] directed_samples [27] = '{
    SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
    SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN,
    SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
    SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
    SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
    SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
    SAMPLE_MAX, 32'hFFFF_FFFF, SAMPLE_MIN,
    32'hFFFF_FFFE, 32'h0001_8000, 32'h0000_0000,
    SAMPLE_MIN, 32'h0000_0000, SAMPLE_MAX
  };

  jacobi_five_point_stencil dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_new_value (out_new_value),
    .out_max_error (out_max_error),
    .out_last_point(out_last_point),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case a beat never arrives.
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // Mix extremes, small values around zero and full-range noise.
  function automatic logic [DATA_W-1:0] draw_sample();
    logic [DATA_W-1:0] near;
    near = DATA_W'($urandom_range(0, 32'h000F_FFFF));
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return near - 32'h0008_0000;
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // Send one beat after a random gap. Valid stays high after acceptance so a
  // zero gap gives back-to-back beats; callers drop it when a run ends.
  task automatic send_sample(input logic [DATA_W-1:0] s);
    int gap;
    gap = draw_wait(tx_calm);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
  endtask

  task automatic run_samples(input int count);
    repeat (count) send_sample(draw_sample());
    in_valid <= 1'b0;
  endtask

  // Hold the write until taken; the caller drops cfg_valid after a batch.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Wait out every expected point, then let beats with no result clear the
  // pipeline before anything touches the registers.
  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Pick new settings for a phase. Widen the grid only at a frame start, so
  // every line-store entry feeding a result was written in this frame; a
  // narrower grid or any row count may land mid-frame.
  task automatic pick_settings(input int phase);
    logic [COLS_W-1:0]     cols_v;
    logic [4:0]            junk;
    logic [CFG_DATA_W-1:0] rows_v;
    junk = 5'($urandom());
    if (phase == 0 || $urandom_range(0, 1) == 1) begin
      if (sb.at_frame_start()) cols_v = COLS_W'($urandom_range(0, 12));
      else cols_v = COLS_W'($urandom_range(0, sb.eff_cols()));
      cfg_write(CFG_GRID_COLS, {junk, cols_v});
    end
    if (phase == 0 || $urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 15))
        0:       rows_v = '1;
        1:       rows_v = CFG_DATA_W'($urandom());
        2:       rows_v = CFG_DATA_W'($urandom_range(0, 2));
        default: rows_v = CFG_DATA_W'($urandom_range(3, 10));
      endcase
      // open with the tallest frame so a later write has to cut it short
      if (phase == 0) rows_v = '1;
      cfg_write(CFG_GRID_ROWS, rows_v);
    end
    if ($urandom_range(0, 1) == 1) cfg_write(CFG_ERROR_ENABLE, CFG_DATA_W'($urandom()));
    if ($urandom_range(0, 7) == 0) cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  // Result side: stall a random number of cycles per beat, then take it.
  initial begin
    int stall;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_wait(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_point(out_new_value, out_max_error, out_last_point);
    end
  end

  initial begin
    int  random_items;
    int  phase;
    int  count;
    bit  big_done;
    sb = new();
    random_items = 0;
    phase        = 0;
    big_done     = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: two 3x3 frames with error tracking on, then one with it off
    // and out-of-range sizes that clamp to 3.
    cfg_write(CFG_GRID_COLS, 16'd3);
    cfg_write(CFG_GRID_ROWS, 16'd3);
    cfg_write(CFG_ERROR_ENABLE, 16'd1);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 18; i++) send_sample(directed_samples[i]);
    in_valid <= 1'b0;
    drain();
    cfg_write(CFG_GRID_COLS, 16'hF800);
    cfg_write(CFG_GRID_ROWS, 16'd2);
    cfg_write(CFG_ERROR_ENABLE, 16'hFFFE);
    cfg_valid <= 1'b0;
    for (int i = 18; i < 27; i++) send_sample(directed_samples[i]);
    in_valid <= 1'b0;

    // Random phases; each starts from an empty pipeline.
    while (random_items < RANDOM_ITEMS) begin
      drain();
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);

      if (!big_done && random_items >= BIG_FRAME_AT) begin
        // Close the current frame early, then open a frame with the column
        // register far past the line-store depth: row 0 has to end at the
        // clamped width. Narrow the grid a few columns into row 1 so that
        // row ends at once and the short row 2 gives points whose inputs
        // depend on where row 0 ended.
        cfg_write(CFG_GRID_ROWS, 16'd3);
        cfg_valid <= 1'b0;
        while (!sb.at_frame_start()) send_sample(draw_sample());
        in_valid <= 1'b0;
        drain();
        cfg_write(CFG_GRID_COLS, 16'hFFFF);
        cfg_write(CFG_GRID_ROWS, 16'h0000);
        cfg_write(CFG_ERROR_ENABLE, 16'h0001);
        cfg_valid <= 1'b0;
        run_samples(LINE_DEPTH + WIDE_TAIL);
        drain();
        cfg_write(CFG_GRID_COLS, CFG_DATA_W'(WIDE_TAIL));
        cfg_valid <= 1'b0;
        run_samples(WIDE_TAIL + 1);
        random_items += LINE_DEPTH + 2 * WIDE_TAIL + 1;
        big_done = 1'b1;
      end else begin
        pick_settings(phase);
        count = $urandom_range(10, 120);
        run_samples(count);
        random_items += count;
        phase++;
      end
    end

    drain();
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
